/* rtl/sbba_pkg.sv */
package sbba_pkg;

  localparam int POOL_COUNT = 6;
  localparam int POOL_W     = 3;
  localparam int POOL_BITS  = 4096;
  localparam int ID_W       = 12;
  localparam int WORD_W     = 64;
  localparam int BIT_W      = 6;
  localparam int WORD_AW    = ID_W - BIT_W;
  localparam int BM_DEPTH   = POOL_COUNT * (POOL_BITS / WORD_W);
  localparam int BM_AW      = POOL_W + WORD_AW;
  localparam int MAX_SHARDS = 16;
  localparam int SHARD_W    = 4;
  localparam int CUR_DEPTH  = POOL_COUNT * MAX_SHARDS;
  localparam int CUR_AW     = POOL_W + SHARD_W;
  localparam int MAX_BATCH  = 16;
  localparam int BATCH_W    = 4;
  localparam int CNT_W      = 5;
  localparam int USED_W     = 13;
  localparam int SC_W       = 5;
  localparam int DIV_NUM_W  = 17;
  localparam int DIV_DEN_W  = 13;
  localparam int DIV_CNT_W  = 5;
  localparam int CLR_W      = 9;

  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_NO_SPACE      = 2'd1;
  localparam logic [1:0] ST_OUT_OF_RANGE  = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOCATED = 2'd3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [2:0]  pool;
    logic [7:0]  worker;
    logic [4:0]  count;
    logic [15:0] free_id;
  } req_t;

  typedef struct packed {
    logic [11:0] block_id;
    logic [1:0]  status;
    logic        last;
    logic [12:0] used_count;
  } res_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DIV, S_DIV_DONE, S_CUR_RD, S_CUR_Q, S_CLAIM, S_SEG,
    S_RD, S_CHK, S_CUR_WB, S_EMIT, S_REL, S_REL_RD, S_REL_WR, S_FREE_RD,
    S_FREE_CHK
  } state_t;

  typedef enum logic [1:0] {DV_SHARD, DV_BEGIN, DV_END, DV_CUR} div_sel_t;

endpackage

/* rtl/sharded_bitmap_block_allocator.sv */
// Bitmap id allocator for six pools of 4096 ids. After reset the block is busy while it
// clears the bitmap and cursor memories. A free reads the bitmap word, then checks and clears
// the bit. An allocate first finds its shard bounds (four serial 17-bit divisions and a cursor
// read), then finds each id by reading and checking one 64-bit bitmap word at a time through
// the single bitmap memory, so the search grows longer as the pool fills; the ids then
// leave one per cycle. A failed batch releases its ids one by one before its single
// no_space result. Results appear on out_valid for one cycle each and cannot be held off.
module sharded_bitmap_block_allocator (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  sbba_pkg::req_t          in_item,
  output logic                    out_valid,
  output sbba_pkg::res_t          out_item,
  input  logic                    cfg_we,
  input  logic [sbba_pkg::SC_W-1:0] cfg_wdata
);

  sbba_pkg::state_t   state_r, state_nxt;
  sbba_pkg::req_t     req_r, req_nxt;
  sbba_pkg::div_sel_t div_sel_r, div_sel_nxt;
  sbba_pkg::res_t     out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [sbba_pkg::SC_W-1:0]      sc_r;
  logic [sbba_pkg::SHARD_W-1:0]   shard_r, shard_nxt;
  logic [sbba_pkg::USED_W-1:0]    begin_r, begin_nxt, end_r, end_nxt;
  logic [sbba_pkg::ID_W-1:0]      start_r, start_nxt, cur_r, cur_nxt;
  logic [1:0]                     seg_r, seg_nxt;
  logic [sbba_pkg::USED_W-1:0]    seg_lo_r, seg_lo_nxt, seg_hi_r, seg_hi_nxt;
  logic [sbba_pkg::WORD_AW-1:0]   word_r, word_nxt;
  logic [sbba_pkg::CNT_W-1:0]     idx_r, idx_nxt, cnt_r, cnt_nxt;
  logic [sbba_pkg::USED_W-1:0]    before_r, before_nxt;
  logic                           fail_r, fail_nxt;
  logic [sbba_pkg::DIV_NUM_W-1:0] dq_r, dq_nxt;
  logic [sbba_pkg::DIV_DEN_W-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [sbba_pkg::DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [sbba_pkg::CLR_W-1:0]     clr_r, clr_nxt;
  logic [sbba_pkg::USED_W-1:0]    pool_used_r [sbba_pkg::POOL_COUNT];
  logic [sbba_pkg::USED_W-1:0]    pool_used_nxt [sbba_pkg::POOL_COUNT];
  logic [sbba_pkg::ID_W-1:0]      ids_r [sbba_pkg::MAX_BATCH];

  logic                           ids_we;
  logic [sbba_pkg::ID_W-1:0]      ids_wdata, ids_rd;

  logic                           bm_we, bm_re;
  logic [sbba_pkg::BM_AW-1:0]     bm_waddr, bm_raddr;
  logic [sbba_pkg::WORD_W-1:0]    bm_wdata, bm_q;
  logic                           cur_we, cur_re;
  logic [sbba_pkg::CUR_AW-1:0]    cur_waddr, cur_raddr;
  logic [sbba_pkg::ID_W-1:0]      cur_wdata, cur_q;

  logic [sbba_pkg::POOL_W-1:0]    pu_idx;
  logic [sbba_pkg::USED_W-1:0]    pu_cur;
  logic [sbba_pkg::USED_W-1:0]    span, bs, lo, hi, seg_hm1;
  logic [sbba_pkg::BIT_W-1:0]     lo_b, hi_b, pos;
  logic [sbba_pkg::WORD_W-1:0]    mask, cand, one_hot;
  logic [sbba_pkg::DIV_DEN_W:0]   rem_sh;
  logic                           div_ge;
  logic [sbba_pkg::CNT_W-1:0]     idx_inc;
  logic                           accept;

  sbba_ram #(.WIDTH(sbba_pkg::WORD_W), .DEPTH(sbba_pkg::BM_DEPTH)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .re(bm_re), .raddr(bm_raddr), .rdata(bm_q)
  );

  sbba_ram #(.WIDTH(sbba_pkg::ID_W), .DEPTH(sbba_pkg::CUR_DEPTH)) u_cursor (
    .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .re(cur_re), .raddr(cur_raddr), .rdata(cur_q)
  );

  assign busy      = (state_r != sbba_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign ids_rd    = ids_r[idx_r[sbba_pkg::BATCH_W-1:0]];
  assign idx_inc   = idx_r + 1'b1;

  assign pu_idx = busy ? req_r.pool : in_item.pool;
  assign pu_cur = (32'(pu_idx) < sbba_pkg::POOL_COUNT) ? pool_used_r[pu_idx] : '0;

  assign span    = end_r - begin_r;
  assign bs      = begin_r + sbba_pkg::USED_W'(start_r);
  assign seg_hm1 = seg_hi_r - 1'b1;
  assign lo_b    = (word_r == seg_lo_r[sbba_pkg::ID_W-1:sbba_pkg::BIT_W]) ?
                   seg_lo_r[sbba_pkg::BIT_W-1:0] : '0;
  assign hi_b    = (word_r == seg_hm1[sbba_pkg::ID_W-1:sbba_pkg::BIT_W]) ?
                   seg_hm1[sbba_pkg::BIT_W-1:0] : '1;
  assign cand    = ~bm_q & mask;
  assign one_hot = {{(sbba_pkg::WORD_W-1){1'b0}}, 1'b1} << pos;

  assign rem_sh = {rem_r, dq_r[sbba_pkg::DIV_NUM_W-1]};
  assign div_ge = rem_sh >= {1'b0, den_r};

  always_comb begin
    for (int b = 0; b < sbba_pkg::WORD_W; b++) begin
      mask[b] = (sbba_pkg::BIT_W'(b) >= lo_b) && (sbba_pkg::BIT_W'(b) <= hi_b);
    end
    pos = '0;
    for (int b = sbba_pkg::WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        pos = sbba_pkg::BIT_W'(b);
      end
    end
  end

  always_comb begin
    unique case (seg_r)
      2'd0: begin
        lo = bs;
        hi = end_r;
      end
      2'd1: begin
        lo = begin_r;
        hi = bs;
      end
      2'd2: begin
        lo = end_r;
        hi = sbba_pkg::USED_W'(sbba_pkg::POOL_BITS);
      end
      default: begin
        lo = '0;
        hi = begin_r;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    div_sel_nxt   = div_sel_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    shard_nxt     = shard_r;
    begin_nxt     = begin_r;
    end_nxt       = end_r;
    start_nxt     = start_r;
    cur_nxt       = cur_r;
    seg_nxt       = seg_r;
    seg_lo_nxt    = seg_lo_r;
    seg_hi_nxt    = seg_hi_r;
    word_nxt      = word_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    before_nxt    = before_r;
    fail_nxt      = fail_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    dcnt_nxt      = dcnt_r;
    clr_nxt       = clr_r;
    pool_used_nxt = pool_used_r;
    ids_we        = 1'b0;
    ids_wdata     = {word_r, pos};
    bm_we         = 1'b0;
    bm_waddr      = {req_r.pool, word_r};
    bm_wdata      = bm_q | one_hot;
    bm_re         = 1'b0;
    bm_raddr      = {req_r.pool, word_r};
    cur_we        = 1'b0;
    cur_waddr     = {req_r.pool, shard_r};
    cur_wdata     = cur_r;
    cur_re        = 1'b0;
    cur_raddr     = {req_r.pool, shard_r};

    unique case (state_r)
      sbba_pkg::S_CLR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_r;
        bm_wdata = '0;
        if (32'(clr_r) < sbba_pkg::CUR_DEPTH) begin
          cur_we = 1'b1;
        end
        cur_waddr = clr_r[sbba_pkg::CUR_AW-1:0];
        cur_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (32'(clr_r) == sbba_pkg::BM_DEPTH - 1) begin
          state_nxt = sbba_pkg::S_IDLE;
        end
      end
      sbba_pkg::S_IDLE: begin
        if (accept) begin
          req_nxt = in_item;
          out_nxt.block_id = '0;
          out_nxt.last     = 1'b1;
          if (32'(in_item.pool) >= sbba_pkg::POOL_COUNT) begin
            if (!(in_item.action == sbba_pkg::ACT_ALLOC && in_item.count == '0)) begin
              out_valid_nxt       = 1'b1;
              out_nxt.status      = sbba_pkg::ST_OUT_OF_RANGE;
              out_nxt.used_count  = '0;
            end
          end else if (in_item.action == sbba_pkg::ACT_FREE) begin
            if (32'(in_item.free_id) >= sbba_pkg::POOL_BITS) begin
              out_valid_nxt      = 1'b1;
              out_nxt.status     = sbba_pkg::ST_OUT_OF_RANGE;
              out_nxt.used_count = pu_cur;
            end else begin
              state_nxt = sbba_pkg::S_FREE_RD;
            end
          end else if (in_item.count != '0) begin
            cnt_nxt     = (32'(in_item.count) > sbba_pkg::MAX_BATCH) ?
                          sbba_pkg::CNT_W'(sbba_pkg::MAX_BATCH) : in_item.count;
            before_nxt  = pu_cur;
            idx_nxt     = '0;
            dq_nxt      = sbba_pkg::DIV_NUM_W'(in_item.worker);
            den_nxt     = sbba_pkg::DIV_DEN_W'(sc_r);
            rem_nxt     = '0;
            dcnt_nxt    = '0;
            div_sel_nxt = sbba_pkg::DV_SHARD;
            state_nxt   = sbba_pkg::S_DIV;
          end
        end
      end
      sbba_pkg::S_DIV: begin
        rem_nxt  = div_ge ? sbba_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_r}) :
                            sbba_pkg::DIV_DEN_W'(rem_sh);
        dq_nxt   = {dq_r[sbba_pkg::DIV_NUM_W-2:0], div_ge};
        dcnt_nxt = dcnt_r + 1'b1;
        if (32'(dcnt_r) == sbba_pkg::DIV_NUM_W - 1) begin
          state_nxt = sbba_pkg::S_DIV_DONE;
        end
      end
      sbba_pkg::S_DIV_DONE: begin
        rem_nxt  = '0;
        dcnt_nxt = '0;
        den_nxt  = sbba_pkg::DIV_DEN_W'(sc_r);
        unique case (div_sel_r)
          sbba_pkg::DV_SHARD: begin
            shard_nxt   = rem_r[sbba_pkg::SHARD_W-1:0];
            dq_nxt      = sbba_pkg::DIV_NUM_W'(rem_r[sbba_pkg::SHARD_W-1:0]) << sbba_pkg::ID_W;
            div_sel_nxt = sbba_pkg::DV_BEGIN;
            state_nxt   = sbba_pkg::S_DIV;
          end
          sbba_pkg::DV_BEGIN: begin
            begin_nxt   = dq_r[sbba_pkg::USED_W-1:0];
            dq_nxt      = sbba_pkg::DIV_NUM_W'({1'b0, shard_r} + 1'b1) << sbba_pkg::ID_W;
            div_sel_nxt = sbba_pkg::DV_END;
            state_nxt   = sbba_pkg::S_DIV;
          end
          sbba_pkg::DV_END: begin
            end_nxt   = dq_r[sbba_pkg::USED_W-1:0];
            state_nxt = sbba_pkg::S_CUR_RD;
          end
          default: begin
            cur_nxt   = rem_r[sbba_pkg::ID_W-1:0];
            state_nxt = sbba_pkg::S_CLAIM;
          end
        endcase
      end
      sbba_pkg::S_CUR_RD: begin
        cur_re    = 1'b1;
        state_nxt = sbba_pkg::S_CUR_Q;
      end
      sbba_pkg::S_CUR_Q: begin
        dq_nxt      = sbba_pkg::DIV_NUM_W'(cur_q);
        den_nxt     = span;
        rem_nxt     = '0;
        dcnt_nxt    = '0;
        div_sel_nxt = sbba_pkg::DV_CUR;
        state_nxt   = sbba_pkg::S_DIV;
      end
      sbba_pkg::S_CLAIM: begin
        start_nxt = cur_r;
        cur_nxt   = (sbba_pkg::USED_W'(cur_r) + 1'b1 == span) ? '0 : cur_r + 1'b1;
        seg_nxt   = '0;
        state_nxt = sbba_pkg::S_SEG;
      end
      sbba_pkg::S_SEG: begin
        if (lo < hi) begin
          seg_lo_nxt = lo;
          seg_hi_nxt = hi;
          word_nxt   = lo[sbba_pkg::ID_W-1:sbba_pkg::BIT_W];
          state_nxt  = sbba_pkg::S_RD;
        end else if (seg_r == 2'd3) begin
          pool_used_nxt[req_r.pool] = before_r;
          fail_nxt  = 1'b1;
          state_nxt = sbba_pkg::S_CUR_WB;
        end else begin
          seg_nxt = seg_r + 1'b1;
        end
      end
      sbba_pkg::S_RD: begin
        bm_re     = 1'b1;
        state_nxt = sbba_pkg::S_CHK;
      end
      sbba_pkg::S_CHK: begin
        if (|cand) begin
          bm_we   = 1'b1;
          ids_we  = 1'b1;
          idx_nxt = idx_inc;
          pool_used_nxt[req_r.pool] = pool_used_r[req_r.pool] + 1'b1;
          if (idx_inc == cnt_r) begin
            fail_nxt  = 1'b0;
            state_nxt = sbba_pkg::S_CUR_WB;
          end else begin
            state_nxt = sbba_pkg::S_CLAIM;
          end
        end else if (word_r == seg_hm1[sbba_pkg::ID_W-1:sbba_pkg::BIT_W]) begin
          if (seg_r == 2'd3) begin
            pool_used_nxt[req_r.pool] = before_r;
            fail_nxt  = 1'b1;
            state_nxt = sbba_pkg::S_CUR_WB;
          end else begin
            seg_nxt   = seg_r + 1'b1;
            state_nxt = sbba_pkg::S_SEG;
          end
        end else begin
          word_nxt  = word_r + 1'b1;
          state_nxt = sbba_pkg::S_RD;
        end
      end
      sbba_pkg::S_CUR_WB: begin
        cur_we = 1'b1;
        if (fail_r) begin
          state_nxt = sbba_pkg::S_REL;
        end else begin
          idx_nxt   = '0;
          state_nxt = sbba_pkg::S_EMIT;
        end
      end
      sbba_pkg::S_EMIT: begin
        out_valid_nxt      = 1'b1;
        out_nxt.block_id   = ids_rd;
        out_nxt.status     = sbba_pkg::ST_OK;
        out_nxt.last       = (idx_inc == cnt_r);
        out_nxt.used_count = before_r + sbba_pkg::USED_W'(idx_inc);
        idx_nxt            = idx_inc;
        if (idx_inc == cnt_r) begin
          state_nxt = sbba_pkg::S_IDLE;
        end
      end
      sbba_pkg::S_REL: begin
        if (idx_r == '0) begin
          out_valid_nxt      = 1'b1;
          out_nxt.block_id   = '0;
          out_nxt.status     = sbba_pkg::ST_NO_SPACE;
          out_nxt.last       = 1'b1;
          out_nxt.used_count = before_r;
          state_nxt          = sbba_pkg::S_IDLE;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = sbba_pkg::S_REL_RD;
        end
      end
      sbba_pkg::S_REL_RD: begin
        bm_re     = 1'b1;
        bm_raddr  = {req_r.pool, ids_rd[sbba_pkg::ID_W-1:sbba_pkg::BIT_W]};
        state_nxt = sbba_pkg::S_REL_WR;
      end
      sbba_pkg::S_REL_WR: begin
        bm_we     = 1'b1;
        bm_waddr  = {req_r.pool, ids_rd[sbba_pkg::ID_W-1:sbba_pkg::BIT_W]};
        bm_wdata  = bm_q & ~({{(sbba_pkg::WORD_W-1){1'b0}}, 1'b1} <<
                             ids_rd[sbba_pkg::BIT_W-1:0]);
        state_nxt = sbba_pkg::S_REL;
      end
      sbba_pkg::S_FREE_RD: begin
        bm_re     = 1'b1;
        bm_raddr  = {req_r.pool, req_r.free_id[sbba_pkg::ID_W-1:sbba_pkg::BIT_W]};
        state_nxt = sbba_pkg::S_FREE_CHK;
      end
      sbba_pkg::S_FREE_CHK: begin
        out_valid_nxt    = 1'b1;
        out_nxt.block_id = '0;
        out_nxt.last     = 1'b1;
        bm_waddr = {req_r.pool, req_r.free_id[sbba_pkg::ID_W-1:sbba_pkg::BIT_W]};
        bm_wdata = bm_q & ~({{(sbba_pkg::WORD_W-1){1'b0}}, 1'b1} <<
                            req_r.free_id[sbba_pkg::BIT_W-1:0]);
        if (bm_q[req_r.free_id[sbba_pkg::BIT_W-1:0]]) begin
          bm_we              = 1'b1;
          pool_used_nxt[req_r.pool] = pool_used_r[req_r.pool] - 1'b1;
          out_nxt.status     = sbba_pkg::ST_OK;
          out_nxt.used_count = pool_used_r[req_r.pool] - 1'b1;
        end else begin
          out_nxt.status     = sbba_pkg::ST_NOT_ALLOCATED;
          out_nxt.used_count = pool_used_r[req_r.pool];
        end
        state_nxt = sbba_pkg::S_IDLE;
      end
      default: begin
        state_nxt = sbba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbba_pkg::S_CLR;
      clr_r       <= '0;
      sc_r        <= sbba_pkg::SC_W'(1);
      out_valid_r <= 1'b0;
      for (int p = 0; p < sbba_pkg::POOL_COUNT; p++) begin
        pool_used_r[p] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      pool_used_r <= pool_used_nxt;
      if (cfg_we) begin
        if (cfg_wdata == '0) begin
          sc_r <= sbba_pkg::SC_W'(1);
        end else if (32'(cfg_wdata) > sbba_pkg::MAX_SHARDS) begin
          sc_r <= sbba_pkg::SC_W'(sbba_pkg::MAX_SHARDS);
        end else begin
          sc_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    div_sel_r <= div_sel_nxt;
    out_r     <= out_nxt;
    shard_r   <= shard_nxt;
    begin_r   <= begin_nxt;
    end_r     <= end_nxt;
    start_r   <= start_nxt;
    cur_r     <= cur_nxt;
    seg_r     <= seg_nxt;
    seg_lo_r  <= seg_lo_nxt;
    seg_hi_r  <= seg_hi_nxt;
    word_r    <= word_nxt;
    idx_r     <= idx_nxt;
    cnt_r     <= cnt_nxt;
    before_r  <= before_nxt;
    fail_r    <= fail_nxt;
    dq_r      <= dq_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    dcnt_r    <= dcnt_nxt;
    if (ids_we) begin
      ids_r[idx_r[sbba_pkg::BATCH_W-1:0]] <= ids_wdata;
    end
  end

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(bm_we && bm_re))
    else $error("bitmap read and write in the same cycle");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbba_pkg::S_CLR) |-> busy && !out_valid_nxt)
    else $error("item activity during memory clear");

  a_no_space_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != sbba_pkg::ST_OK) |-> out_item.last)
    else $error("error result not marked last");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_item.used_count) <= sbba_pkg::POOL_BITS))
    else $error("used count above pool size");
`endif

endmodule

/* rtl/sbba_ram.sv */
module sbba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* bench/sharded_bitmap_block_allocator_tb.sv */
module sharded_bitmap_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbba_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t in_item = '0;
  logic out_valid;
  res_t out_item;
  logic cfg_we = 1'b0;
  logic [SC_W-1:0] cfg_wdata = '0;

  sharded_bitmap_block_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bit   id_map [POOL_COUNT][POOL_BITS];
  int   used_ids [POOL_COUNT];
  int   cursor [POOL_COUNT][MAX_SHARDS];
  int   shards = 1;
  req_t pending_items [$];
  res_t expected_results [$];
  int   live_ids [$];
  bit   item_taken = 1'b0;
  bit   no_gaps = 1'b0;
  int   errors = 0;

  function automatic req_t mk(logic act, int p, int w, int c, int fid);
    req_t r;
    r.action = act;
    r.pool = 3'(p);
    r.worker = 8'(w);
    r.count = 5'(c);
    r.free_id = 16'(fid);
    return r;
  endfunction

  function automatic res_t mk_res(int id, logic [1:0] st, logic lst, int u);
    res_t r;
    r.block_id = 12'(id);
    r.status = st;
    r.last = lst;
    r.used_count = 13'(u);
    return r;
  endfunction

  function automatic bit grab_id(int p, int sh, output int got);
    int b, e, span, st, off, id;
    b = POOL_BITS * sh / shards;
    e = POOL_BITS * (sh + 1) / shards;
    span = e - b;
    st = 0;
    if (span != 0) begin
      st = cursor[p][sh] % span;
      cursor[p][sh] = (st + 1 == span) ? 0 : st + 1;
    end
    for (int i = 0; i < span; i++) begin
      off = st + i;
      if (off >= span) off -= span;
      if (!id_map[p][b + off]) begin
        id_map[p][b + off] = 1'b1;
        used_ids[p]++;
        got = b + off;
        return 1'b1;
      end
    end
    for (int i = 0; i < POOL_BITS; i++) begin
      id = e + i;
      if (id >= POOL_BITS) id -= POOL_BITS;
      if (id >= b && id < e) continue;
      if (!id_map[p][id]) begin
        id_map[p][id] = 1'b1;
        used_ids[p]++;
        got = id;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_alloc_free(req_t r);
    int p, c, used_before, got;
    int ids [$];
    p = r.pool;
    c = r.count;
    if (p >= POOL_COUNT) begin
      if (!(r.action == ACT_ALLOC && c == 0))
        expected_results.push_back(mk_res(0, ST_OUT_OF_RANGE, 1'b1, 0));
      return;
    end
    if (r.action == ACT_FREE) begin
      if (r.free_id >= POOL_BITS)
        expected_results.push_back(mk_res(0, ST_OUT_OF_RANGE, 1'b1, used_ids[p]));
      else if (!id_map[p][r.free_id])
        expected_results.push_back(mk_res(0, ST_NOT_ALLOCATED, 1'b1, used_ids[p]));
      else begin
        id_map[p][r.free_id] = 1'b0;
        used_ids[p]--;
        expected_results.push_back(mk_res(0, ST_OK, 1'b1, used_ids[p]));
      end
      return;
    end
    if (c == 0) return;
    if (c > MAX_BATCH) c = MAX_BATCH;
    used_before = used_ids[p];
    for (int n = 0; n < c; n++) begin
      if (!grab_id(p, r.worker % shards, got)) begin
        foreach (ids[k]) begin
          id_map[p][ids[k]] = 1'b0;
          used_ids[p]--;
        end
        expected_results.push_back(mk_res(0, ST_NO_SPACE, 1'b1, used_ids[p]));
        return;
      end
      ids.push_back(got);
    end
    foreach (ids[k]) begin
      expected_results.push_back(mk_res(ids[k], ST_OK, k + 1 == c, used_before + k + 1));
      live_ids.push_back(p * POOL_BITS + ids[k]);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          errors++;
        end else begin
          res_t e;
          e = expected_results.pop_front();
          if (e.block_id !== out_item.block_id || e.status !== out_item.status ||
              e.last !== out_item.last || e.used_count !== out_item.used_count) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_item);
            errors++;
          end
        end
      end
      item_taken = start && !busy;
      if (item_taken) predict_alloc_free(in_item);
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!start || item_taken)) begin
      if (pending_items.size() > 0 && (no_gaps || $urandom_range(99) >= 36)) begin
        in_item <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic wait_idle();
    while (pending_items.size() > 0 || start || expected_results.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_shards(int v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= SC_W'(v);
    v = v & 31;
    shards = (v == 0) ? 1 : (v > MAX_SHARDS) ? MAX_SHARDS : v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic req_t random_item();
    int r, k, h;
    r = $urandom_range(99);
    if (r < 5) return mk($urandom_range(1), $urandom_range(7, 6), $urandom_range(255),
                         $urandom_range(31), $urandom);
    if (r < 50) return mk(ACT_ALLOC, $urandom_range(5), $urandom_range(255),
                          ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(4, 1),
                          $urandom);
    if (live_ids.size() > 0 && $urandom_range(9) < 7) begin
      k = $urandom_range(live_ids.size() - 1);
      h = live_ids[k];
      live_ids.delete(k);
      return mk(ACT_FREE, h / POOL_BITS, $urandom_range(255), $urandom_range(31),
                h % POOL_BITS);
    end
    return mk(ACT_FREE, $urandom_range(5), $urandom_range(255), $urandom_range(31),
              $urandom_range(1) ? $urandom_range(65535) : $urandom_range(POOL_BITS - 1));
  endfunction

  initial begin
    int plan [7] = '{0, 16, 31, 5, 3, 1, 7};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    pending_items.push_back(mk(ACT_ALLOC, 6, 0, 1, 0));
    pending_items.push_back(mk(ACT_FREE, 7, 255, 0, 65535));
    pending_items.push_back(mk(ACT_ALLOC, 7, 0, 0, 0));
    pending_items.push_back(mk(ACT_ALLOC, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_ALLOC, 0, 255, 1, 0));
    pending_items.push_back(mk(ACT_ALLOC, 0, 0, 16, 0));
    pending_items.push_back(mk(ACT_ALLOC, 1, 3, 17, 0));
    pending_items.push_back(mk(ACT_ALLOC, 2, 128, 31, 65535));
    pending_items.push_back(mk(ACT_FREE, 0, 0, 0, 4096));
    pending_items.push_back(mk(ACT_FREE, 0, 0, 0, 65535));
    pending_items.push_back(mk(ACT_FREE, 0, 0, 0, 4095));
    pending_items.push_back(mk(ACT_FREE, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_FREE, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_FREE, 1, 0, 31, 5));
    pending_items.push_back(mk(ACT_ALLOC, 0, 1, 2, 0));
    wait_idle();

    foreach (plan[i]) begin
      write_shards(plan[i]);
      no_gaps = (i == 3);
      for (int n = 0; n < 30; n++) pending_items.push_back(random_item());
      wait_idle();
    end
    no_gaps = 1'b0;

    if (errors == 0 && expected_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #30ms;
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/sbba_pkg.sv
rtl/sbba_ram.sv
rtl/sharded_bitmap_block_allocator.sv
bench/sharded_bitmap_block_allocator_tb.sv
